// ===== rtl/core/fgrq_pkg.sv =====
// Shared constants, codes and types of the fence-gated retirement queue.
package fgrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int TAG_W       = 16;
    localparam int VAL_W       = 64;
    localparam int ENTRY_W     = 1 + VAL_W + TAG_W;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_COLLECT = 2'd1,
        OP_FLUSH   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CAUSE_IMMEDIATE = 2'd0,
        CAUSE_COLLECTED = 2'd1,
        CAUSE_FLUSHED   = 2'd2,
        CAUSE_DROPPED   = 2'd3
    } t_cause;

    typedef enum logic [1:0] {
        K_IMMED   = 2'd0,
        K_APPEND  = 2'd1,
        K_COLLECT = 2'd2,
        K_FLUSH   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TAG_W-1:0]   tag;
        logic               sig_kind;
        logic [VAL_W-1:0]   val_a;
        logic [VAL_W-1:0]   val_b;
    } t_cmd;

    typedef struct packed {
        logic               idle;
        logic [CNT_W-1:0]   count;
    } t_back_status;

endpackage

// ===== rtl/core/fgrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fgrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fgrq_front.sv =====
// Front end: command transfer handshake and classification into queue commands.
module fgrq_front (
    input  logic                      i_start,
    input  logic [1:0]                i_operation,
    input  logic                      i_has_action,
    input  logic [15:0]               i_action_tag,
    input  logic                      i_signal_kind,
    input  logic [63:0]               i_target_value,
    input  logic [63:0]               i_done_frame,
    input  logic [63:0]               i_done_timeline,
    input  logic                      i_full,
    output logic                      o_push,
    output fgrq_pkg::t_cmd            o_cmd,
    output logic                      o_busy
);

    logic accept;

    assign accept = i_start && !i_full;
    assign o_busy = i_full;

    always_comb begin
        o_push         = 1'b0;
        o_cmd.kind     = fgrq_pkg::K_APPEND;
        o_cmd.tag      = i_action_tag;
        o_cmd.sig_kind = i_signal_kind;
        o_cmd.val_a    = i_target_value;
        o_cmd.val_b    = i_done_timeline;
        unique case (fgrq_pkg::t_op'(i_operation))
            fgrq_pkg::OP_PUSH: begin
                o_push     = accept && i_has_action;
                o_cmd.kind = (i_target_value == '0) ? fgrq_pkg::K_IMMED
                                                    : fgrq_pkg::K_APPEND;
            end
            fgrq_pkg::OP_COLLECT: begin
                o_push      = accept;
                o_cmd.kind  = fgrq_pkg::K_COLLECT;
                o_cmd.val_a = i_done_frame;
            end
            fgrq_pkg::OP_FLUSH: begin
                o_push     = accept;
                o_cmd.kind = fgrq_pkg::K_FLUSH;
            end
            fgrq_pkg::OP_NONE: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/fgrq_fifo.sv =====
// Two-slot command queue between front end and back end.
module fgrq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fgrq_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output fgrq_pkg::t_cmd o_head
);

    fgrq_pkg::t_cmd r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp;
    logic           n_rp;
    logic [1:0]     n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/fgrq_back.sv =====
// Back end: entry table, append, scan with in-place compaction, result strobe.
module fgrq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  fgrq_pkg::t_cmd       i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [15:0]          o_retired_tag,
    output logic [1:0]           o_retire_cause,
    output logic                 o_last,
    output fgrq_pkg::t_back_status o_status
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_SCAN = 2'b10
    } t_bstate;

    t_bstate                           r_state,     n_state;
    logic [fgrq_pkg::CNT_W-1:0]        r_count,     n_count;
    logic [fgrq_pkg::CNT_W-1:0]        r_issue,     n_issue;
    logic [fgrq_pkg::CNT_W-1:0]        r_wr,        n_wr;
    logic                              r_rv,        n_rv;
    logic [fgrq_pkg::RES_W-1:0]        r_n,         n_n;
    logic                              r_hold_v,    n_hold_v;
    logic [fgrq_pkg::TAG_W-1:0]        r_hold_tag,  n_hold_tag;
    logic                              r_flush,     n_flush;
    logic [fgrq_pkg::VAL_W-1:0]        r_frame,     n_frame;
    logic [fgrq_pkg::VAL_W-1:0]        r_tl,        n_tl;
    logic                              r_out_valid, n_out_valid;
    logic [fgrq_pkg::TAG_W-1:0]        r_out_tag,   n_out_tag;
    fgrq_pkg::t_cause                  r_out_cause, n_out_cause;
    logic                              r_out_last,  n_out_last;

    logic                              ram_we;
    logic [fgrq_pkg::IDX_W-1:0]        ram_waddr;
    logic [fgrq_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [fgrq_pkg::IDX_W-1:0]        ram_raddr;
    logic [fgrq_pkg::ENTRY_W-1:0]      ram_rdata;

    logic                              issue_more;
    logic                              rd_kind;
    logic [fgrq_pkg::VAL_W-1:0]        rd_target;
    logic [fgrq_pkg::TAG_W-1:0]        rd_tag;
    logic                              hit;
    fgrq_pkg::t_cause                  scan_cause;

    fgrq_ram #(
        .WIDTH (fgrq_pkg::ENTRY_W),
        .DEPTH (fgrq_pkg::QUEUE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_kind    = ram_rdata[fgrq_pkg::ENTRY_W-1];
    assign rd_target  = ram_rdata[fgrq_pkg::TAG_W +: fgrq_pkg::VAL_W];
    assign rd_tag     = ram_rdata[fgrq_pkg::TAG_W-1:0];
    assign hit        = r_flush || (rd_kind ? (r_tl >= rd_target) : (r_frame >= rd_target));
    assign issue_more = (r_issue < r_count);
    assign scan_cause = r_flush ? fgrq_pkg::CAUSE_FLUSHED : fgrq_pkg::CAUSE_COLLECTED;
    assign ram_raddr  = r_issue[fgrq_pkg::IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_wr        = r_wr;
        n_rv        = r_rv;
        n_n         = r_n;
        n_hold_v    = r_hold_v;
        n_hold_tag  = r_hold_tag;
        n_flush     = r_flush;
        n_frame     = r_frame;
        n_tl        = r_tl;
        n_out_valid = 1'b0;
        n_out_tag   = r_hold_tag;
        n_out_cause = scan_cause;
        n_out_last  = 1'b0;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wr[fgrq_pkg::IDX_W-1:0];
        ram_wdata   = ram_rdata;
        unique case (r_state)
            B_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.kind)
                        fgrq_pkg::K_IMMED: begin
                            n_out_valid = 1'b1;
                            n_out_tag   = i_head.tag;
                            n_out_cause = fgrq_pkg::CAUSE_IMMEDIATE;
                            n_out_last  = 1'b1;
                        end
                        fgrq_pkg::K_APPEND: begin
                            if (r_count >= fgrq_pkg::CNT_W'(fgrq_pkg::QUEUE_DEPTH)) begin
                                n_out_valid = 1'b1;
                                n_out_tag   = i_head.tag;
                                n_out_cause = fgrq_pkg::CAUSE_DROPPED;
                                n_out_last  = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[fgrq_pkg::IDX_W-1:0];
                                ram_wdata = {i_head.sig_kind, i_head.val_a, i_head.tag};
                                n_count   = r_count + 1'b1;
                            end
                        end
                        fgrq_pkg::K_COLLECT, fgrq_pkg::K_FLUSH: begin
                            n_state  = B_SCAN;
                            n_issue  = '0;
                            n_wr     = '0;
                            n_rv     = 1'b0;
                            n_n      = '0;
                            n_hold_v = 1'b0;
                            n_flush  = (i_head.kind == fgrq_pkg::K_FLUSH);
                            n_frame  = i_head.val_a;
                            n_tl     = i_head.val_b;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                n_rv = issue_more;
                if (issue_more) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_rv) begin
                    if (hit && (r_n < fgrq_pkg::RES_W'(fgrq_pkg::MAX_RESULTS))) begin
                        n_out_valid = r_hold_v;
                        n_hold_v    = 1'b1;
                        n_hold_tag  = rd_tag;
                        n_n         = r_n + 1'b1;
                    end else begin
                        ram_we = 1'b1;
                        n_wr   = r_wr + 1'b1;
                    end
                end else if (!issue_more) begin
                    n_count     = r_wr;
                    n_state     = B_IDLE;
                    n_out_valid = r_hold_v;
                    n_out_last  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_rv        <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rv        <= n_rv;
            r_hold_v    <= n_hold_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue     <= n_issue;
        r_wr        <= n_wr;
        r_n         <= n_n;
        r_hold_tag  <= n_hold_tag;
        r_flush     <= n_flush;
        r_frame     <= n_frame;
        r_tl        <= n_tl;
        r_out_tag   <= n_out_tag;
        r_out_cause <= n_out_cause;
        r_out_last  <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_retired_tag  = r_out_tag;
    assign o_retire_cause = r_out_cause;
    assign o_last         = r_out_last;
    assign o_status.idle  = (r_state == B_IDLE);
    assign o_status.count = r_count;

endmodule

// ===== rtl/core/fence_gated_retirement_queue.sv =====
// Top level of the fence-gated retirement queue: front end, command queue, back end.
//
//  channel   | ports                                              | transfer when
//  ----------+----------------------------------------------------+-----------------------
//  command   | i_start, o_busy, i_operation .. i_done_timeline    | i_start && !o_busy
//  result    | o_valid, o_retired_tag, o_retire_cause, o_last     | o_valid (one cycle)
//
//  A command is taken whenever the two-slot command queue has room; o_busy means it is full.
//  The back end runs one command at a time: a push is handled while idle, a collect or
//  flush runs a scan through the single registered read port of the entry table, walked
//  one entry per cycle. A found result is held until the next hit or the end of the scan
//  and leaves in the cycle after that, in order.
//  Reset (i_rst_n low, synchronous) empties the command queue and the entry table;
//  the receiver cannot stall, results are strobed once and not held.
module fence_gated_retirement_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic        i_has_action,
    input  logic [15:0] i_action_tag,
    input  logic        i_signal_kind,
    input  logic [63:0] i_target_value,
    input  logic [63:0] i_done_frame,
    input  logic [63:0] i_done_timeline,
    output logic        o_valid,
    output logic [15:0] o_retired_tag,
    output logic [1:0]  o_retire_cause,
    output logic        o_last
);

    logic                   push;
    fgrq_pkg::t_cmd         push_cmd;
    logic                   full;
    logic                   head_valid;
    fgrq_pkg::t_cmd         head;
    logic                   pop;
    fgrq_pkg::t_back_status status;

    fgrq_front u_front (
        .i_start         (i_start),
        .i_operation     (i_operation),
        .i_has_action    (i_has_action),
        .i_action_tag    (i_action_tag),
        .i_signal_kind   (i_signal_kind),
        .i_target_value  (i_target_value),
        .i_done_frame    (i_done_frame),
        .i_done_timeline (i_done_timeline),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .o_busy          (o_busy)
    );

    fgrq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    fgrq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_retired_tag  (o_retired_tag),
        .o_retire_cause (o_retire_cause),
        .o_last         (o_last),
        .o_status       (status)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= fgrq_pkg::CNT_W'(fgrq_pkg::QUEUE_DEPTH))
        else $error("entry count above table depth");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_retire_cause == fgrq_pkg::CAUSE_IMMEDIATE
                  || o_retire_cause == fgrq_pkg::CAUSE_DROPPED)) |-> o_last)
        else $error("immediate or dropped result without last");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("command queue filled without a command transfer");

    a_scan_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status.idle |-> !pop)
        else $error("command taken while a scan is running");
`endif

endmodule
